// File: rtl/core/rk4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_pkg
// shared constants, types and helpers of the rk4 integrator
// ----------------------------------------------------------------------------
package rk4_pkg;

	localparam int FracBitsDef = 16;
	localparam int MassW       = 31;
	localparam int DtW         = 17;
	localparam int NumAxes     = 3;
	localparam logic [MassW-1:0] MassRst = 31'd65536;
	localparam logic [DtW-1:0]   DtRst   = 17'd13107;

	localparam logic CfgMass = 1'b0;
	localparam logic CfgDt   = 1'b1;

	localparam logic OpStep = 1'b0;
	localparam logic OpLoad = 1'b1;

	typedef struct packed {
		logic start;
		logic busy;
	} lane_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/rk4_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_lane
// one axis: restoring divider for force/mass, then rk4 update sequence
// ----------------------------------------------------------------------------
module rk4_lane #(
	parameter int FRAC_BITS = rk4_pkg::FracBitsDef
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire rk4_pkg::lane_ctl_t  ctl,
	input  wire  [30:0]              mass,
	input  wire  [16:0]              dt,
	input  wire  signed [31:0]       force_in,
	input  wire  signed [31:0]       pos_in,
	input  wire  signed [31:0]       vel_in,
	output logic                     done,
	output logic signed [31:0]       pos_new,
	output logic signed [31:0]       vel_new,
	output logic                     sat_flag
);
	localparam int NumW = 32 + FRAC_BITS;
	localparam int CntW = $clog2(NumW + 8);
	// divide by six: n = hi*2^18 + lo, 2^18 = 6*43690 + 4
	localparam logic [15:0] SixthHi  = 16'd43690;
	localparam logic [19:0] SixthRcp = 20'd699051;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_UPD  = 4'b1000
	} lst_t;

	lst_t st_q;
	logic [CntW-1:0]   cnt_q;
	logic [NumW-1:0]   quo_q;
	logic [31:0]       rem_q;
	logic              neg_q;
	logic [30:0]       den_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] rp_q;
	logic signed [31:0] dvf_q;
	logic              fl_q;
	logic              sneg_q;
	logic [33:0]       smag_q;
	logic signed [31:0] rate_q;

	logic [32:0]       rem_sh;
	logic [NumW-1:0]   quo_mag;
	logic signed [63:0] acc_w;
	logic signed [31:0] acc32_w;
	logic signed [49:0] pm_w;
	logic signed [49:0] rpm_w;
	logic signed [63:0] dvh_w, dvf_w, vb_w, vd_w, sum_w, dp_w, pn_w, vn_w;
	logic signed [31:0] vb_s, vd_s, dvh_s, dvf_s;
	logic [18:0]       m6_w;
	logic [38:0]       mq_w;
	logic [31:0]       qhi_w;
	logic [31:0]       q_w;
	logic signed [31:0] rate_w;

	assign rem_sh = {rem_q, quo_q[NumW-1]};
	assign quo_mag = quo_q;
	assign acc_w = neg_q ? -$signed({{(64-NumW){1'b0}}, quo_mag})
	                     :  $signed({{(64-NumW){1'b0}}, quo_mag});
	assign acc32_w = rk4_pkg::sat32(acc_w);
	assign pm_w  = acc32_w * $signed({1'b0, dt});
	assign rpm_w = rate_q * $signed({1'b0, dt});

	// combinational update from the registered products and stage sums
	always_comb begin
		dvh_w = prod_q >>> (FRAC_BITS + 1);
		dvf_w = prod_q >>> FRAC_BITS;
		dvh_s = rk4_pkg::sat32(dvh_w);
		dvf_s = rk4_pkg::sat32(dvf_w);
		vb_w  = 64'(vel_in) + 64'(dvh_s);
		vd_w  = 64'(vel_in) + 64'(dvf_s);
		vb_s  = rk4_pkg::sat32(vb_w);
		vd_s  = rk4_pkg::sat32(vd_w);
		sum_w = 64'(vel_in) + 4 * 64'(vb_s) + 64'(vd_s);
		// magnitude of the weighted sum over six, truncated toward zero
		m6_w  = {1'b0, smag_q[17:0]} + {1'b0, smag_q[33:18], 2'b00};
		mq_w  = m6_w * SixthRcp;
		qhi_w = smag_q[33:18] * SixthHi;
		q_w   = qhi_w + {15'd0, mq_w[38:22]};
		rate_w = sneg_q ? -$signed(q_w) : $signed(q_w);
		dp_w  = rp_q >>> FRAC_BITS;
		pn_w  = 64'(pos_in) + 64'(rk4_pkg::sat32(dp_w));
		vn_w  = 64'(vel_in) + 64'(dvf_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (ctl.start) begin
						st_q <= ST_DIV;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(NumW - 1))
						st_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(NumW + 3))
						st_q <= ST_UPD;
				end
				ST_UPD: begin
					st_q <= ST_IDLE;
					done <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				neg_q <= force_in[31];
				quo_q <= {(force_in[31] ? 32'(-force_in) : 32'(force_in)),
				          {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				den_q <= (mass == '0) ? 31'd1 : mass;
				fl_q <= 1'b0;
			end
			ST_DIV: begin
				if (rem_sh >= {2'b0, den_q}) begin
					rem_q <= 32'(rem_sh - {2'b0, den_q});
					quo_q <= {quo_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quo_q <= {quo_q[NumW-2:0], 1'b0};
				end
			end
			ST_MUL: begin
				if (cnt_q == CntW'(NumW)) begin
					fl_q <= rk4_pkg::ovf32(acc_w);
					prod_q <= 64'(pm_w);
				end else if (cnt_q == CntW'(NumW + 1)) begin
					// stage velocities and their weighted sum
					fl_q <= fl_q | rk4_pkg::ovf32(dvh_w) | rk4_pkg::ovf32(dvf_w)
					      | rk4_pkg::ovf32(vb_w) | rk4_pkg::ovf32(vd_w);
					dvf_q <= dvf_s;
					sneg_q <= sum_w[63];
					smag_q <= 34'(sum_w[63] ? -sum_w : sum_w);
				end else if (cnt_q == CntW'(NumW + 2)) begin
					rate_q <= rate_w;
				end else begin
					rp_q <= 64'(rpm_w);
				end
			end
			ST_UPD: begin
				pos_new <= rk4_pkg::sat32(pn_w);
				vel_new <= rk4_pkg::sat32(vn_w);
				sat_flag <= fl_q | rk4_pkg::ovf32(dp_w) | rk4_pkg::ovf32(pn_w)
				          | rk4_pkg::ovf32(vn_w);
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_done_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q == ST_UPD)) else $error("lane done without update");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.start && st_q == ST_IDLE) |=> st_q == ST_DIV) else $error("lane did not start");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(NumW + 4)) else $error("lane counter overrun");
`endif
endmodule
`default_nettype wire

// File: rtl/core/rk4_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_merge
// combines lane results or load values into the state and the output payload register
// ----------------------------------------------------------------------------
module rk4_merge (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  wire  [95:0]       load_pos,
	input  wire  [95:0]       load_vel,
	input  wire  [2:0]        lane_done,
	input  wire  [95:0]       lane_pos,
	input  wire  [95:0]       lane_vel,
	input  wire  [2:0]        lane_sat,
	input  wire               out_take,
	output logic [95:0]       pos_q,
	output logic [95:0]       vel_q,
	output logic              sat_q,
	output logic              out_valid_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q <= load_pos;
				vel_q <= load_vel;
				sat_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (lane_done[0]) begin
				pos_q <= lane_pos;
				vel_q <= lane_vel;
				sat_q <= |lane_sat;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_lanes_together: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (lane_done == 3'b111)) else $error("lanes out of step");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && lane_done[0])) else $error("load collides with step");
`endif
endmodule
`default_nettype wire

// File: rtl/core/rk4_constant_force_integrator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_constant_force_integrator_unit
// one-particle rk4 integrator under constant force, three parallel axis lanes
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per transaction: opcode in tuser, forces and
//   load values in tdata. m_axis returns the new state and saturation flag.
//   cfg writes particle_mass (index 0) or time_step (index 1); the user
//   must write them only while idle, which the block itself does not enforce.
// sequence: a load result is valid in the cycle after acceptance; a step
//   runs 32+FRAC_BITS divide iterations in the bit-serial divider of each
//   lane, then product, stage sum, divide by six and rate product, then
//   an update and a merge
// throughput: one item at a time; s_axis_tready returns once the result
//   register is empty or being taken
// reset: state zero, mass 1.0, dt about 0.2, no result pending
// stall: a result holds in the output register until m_axis_tready
// ----------------------------------------------------------------------------
module rk4_constant_force_integrator_unit #(
	parameter int FRAC_BITS = rk4_pkg::FracBitsDef
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [287:0] s_axis_tdata,  // force_x,y,z, load_pos_x,y,z, load_vel_x,y,z
	input  wire  [0:0]   s_axis_tuser,  // opcode
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [191:0] m_axis_tdata,  // pos_x,y,z_out, vel_x,y,z_out
	output logic [0:0]   m_axis_tuser,  // saturated
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [0:0]   cfg_index,
	input  wire  [31:0]  cfg_data
);
	logic [30:0] mass_q;
	logic [16:0] dt_q;
	logic        busy_q;
	logic [95:0] pos_q, vel_q;
	logic        sat_q, oval_q;
	logic [2:0]  ldone, lsat;
	logic [95:0] lpos, lvel;
	logic        acc_in, load_go;
	rk4_pkg::lane_ctl_t ctl;

	assign cfg_ready = 1'b1;
	// one item in flight; accept only once the output slot is free
	assign s_axis_tready = !busy_q && (!oval_q || m_axis_tready);
	assign acc_in  = s_axis_tvalid && s_axis_tready;
	assign load_go = acc_in && (s_axis_tuser[0] == rk4_pkg::OpLoad);
	assign ctl.start = acc_in && (s_axis_tuser[0] == rk4_pkg::OpStep);
	assign ctl.busy  = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= rk4_pkg::MassRst;
			dt_q <= rk4_pkg::DtRst;
			busy_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index[0])
					rk4_pkg::CfgMass: mass_q <= cfg_data[30:0];
					rk4_pkg::CfgDt:   dt_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (ctl.start)
				busy_q <= 1'b1;
			else if (ldone[0])
				busy_q <= 1'b0;
		end
	end

	// one lane per axis
	for (genvar a = 0; a < rk4_pkg::NumAxes; a++) begin : g_lane
		rk4_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .mass(mass_q), .dt(dt_q),
			.force_in(s_axis_tdata[32*a +: 32]),
			.pos_in(pos_q[32*a +: 32]), .vel_in(vel_q[32*a +: 32]),
			.done(ldone[a]), .pos_new(lpos[32*a +: 32]),
			.vel_new(lvel[32*a +: 32]), .sat_flag(lsat[a])
		);
	end

	rk4_merge u_merge (
		.clk(clk), .arst_n(arst_n), .load(load_go),
		.load_pos(s_axis_tdata[191:96]), .load_vel(s_axis_tdata[287:192]),
		.lane_done(ldone), .lane_pos(lpos), .lane_vel(lvel), .lane_sat(lsat),
		.out_take(m_axis_tready), .pos_q(pos_q), .vel_q(vel_q), .sat_q(sat_q),
		.out_valid_q(oval_q)
	);

	assign m_axis_tvalid = oval_q;
	assign m_axis_tdata = {vel_q, pos_q};
	assign m_axis_tuser = sat_q;

`ifndef ASSERT_OFF
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_axis_tready) else $error("accept while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ldone[0] |=> m_axis_tvalid) else $error("result lost");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> busy_q) else $error("busy not set");
`endif
endmodule
`default_nettype wire
